// ===== rtl/core/modular_exponentiation_64_top_macros.svh =====
// Assertion macros used by the datapath of the modular exponentiation core.
`ifndef MODULAR_EXPONENTIATION_64_TOP_MACROS_SVH
`define MODULAR_EXPONENTIATION_64_TOP_MACROS_SVH
`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define MEXP_ASSERT_HOLD(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("mexp assertion failed");
// Condition that must hold in the cycle after the trigger.
`define MEXP_ASSERT_NEXT(label, clk, rst, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("mexp assertion failed");
`else
`define MEXP_ASSERT_HOLD(label, clk, rst, prop)
`define MEXP_ASSERT_NEXT(label, clk, rst, trig, cons)
`endif
`endif

// ===== rtl/core/mexp_pkg.sv =====
// Shared types and constants of the modular exponentiation core.
package mexp_pkg;

  // Width of every payload field on the channels.
  localparam int unsigned DATA_W = 64;

  // Modular multiply operations run by the datapath.
  typedef enum logic [1:0] {
    OP_REDUCE = 2'd0,  // base mod modulus, as 1 * base
    OP_MULR   = 2'd1,  // result times base power
    OP_SQR    = 2'd2   // base power squared
  } op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture a new request
    logic clear_r;    // force the result to zero
    logic mul_start;  // set up a modular multiply
    op_t  op;         // operation for mul_start
    logic dbl;        // double the accumulator mod m
    logic add;        // add the multiplicand mod m
    logic advance;    // move to the next multiplier bit
    logic wb;         // write the product back
    logic exp_shift;  // move to the next exponent bit
    logic push;       // load the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic m_small;   // modulus is zero or one
    logic mul_bit;   // current multiplier bit
    logic mul_last;  // current multiplier bit is the last one
    logic exp_bit;   // current exponent bit
    logic exp_last;  // current exponent bit is the last one
    op_t  op;        // operation in progress
    logic out_free;  // output register can take a result
  } sts_t;

endpackage

// ===== rtl/core/mexp_if.sv =====
// Request and result channel interfaces of the modular exponentiation core.
interface mexp_in_if import mexp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] base_value;
  logic [DATA_W-1:0] exponent_value;
  logic [DATA_W-1:0] modulus_value;

  modport source (output valid, output base_value, output exponent_value,
                  output modulus_value, input ready);
  modport sink (input valid, input base_value, input exponent_value,
                input modulus_value, output ready);
endinterface

interface mexp_out_if import mexp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] power_result;

  modport source (output valid, output power_result, input ready);
  modport sink (input valid, input power_result, output ready);
endinterface

// ===== rtl/core/mexp_dp.sv =====
// Datapath: operand registers, shift-add-reduce multiplier and output register.
module mexp_dp import mexp_pkg::*; #(
  parameter int unsigned W = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [DATA_W-1:0] base_value,
  input  logic [DATA_W-1:0] exponent_value,
  input  logic [DATA_W-1:0] modulus_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_data
);

  localparam int unsigned CNT_W = $clog2(W);

  logic [W-1:0]     m_reg;
  logic [W-1:0]     e_reg;
  logic [W-1:0]     b_reg;
  logic [W-1:0]     r_reg;
  logic [W-1:0]     acc;
  logic [W-1:0]     mcand;
  logic [W-1:0]     mplier;
  logic [CNT_W-1:0] mul_cnt;
  logic [CNT_W-1:0] exp_cnt;
  op_t              op;
  logic             out_full;
  logic             out_reduced;

  logic [W:0]   dbl_sum;
  logic [W:0]   add_sum;
  logic [W-1:0] dbl_res;
  logic [W-1:0] add_res;

  // Doubling is a shift; one conditional subtract brings it below m.
  always_comb begin
    dbl_sum = {acc, 1'b0};
    if (dbl_sum >= {1'b0, m_reg}) begin
      dbl_sum = dbl_sum - {1'b0, m_reg};
    end
    dbl_res = dbl_sum[W-1:0];
  end

  // Adding the multiplicand, then one conditional subtract.
  always_comb begin
    add_sum = {1'b0, acc} + {1'b0, mcand};
    if (add_sum >= {1'b0, m_reg}) begin
      add_sum = add_sum - {1'b0, m_reg};
    end
    add_res = add_sum[W-1:0];
  end

  // Operand and multiplier registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      b_reg   <= base_value[W-1:0];
      e_reg   <= exponent_value[W-1:0];
      m_reg   <= modulus_value[W-1:0];
      r_reg   <= W'(1);
      exp_cnt <= CNT_W'(W - 1);
    end
    if (cmd.clear_r) begin
      r_reg <= '0;
    end
    if (cmd.mul_start) begin
      acc     <= '0;
      op      <= cmd.op;
      mul_cnt <= CNT_W'(W - 1);
      mplier  <= b_reg;
      case (cmd.op)
        OP_REDUCE: mcand <= W'(1);
        OP_MULR:   mcand <= r_reg;
        OP_SQR:    mcand <= b_reg;
        default:   mcand <= b_reg;
      endcase
    end
    if (cmd.dbl) begin
      acc <= dbl_res;
    end
    if (cmd.add) begin
      acc <= add_res;
    end
    if (cmd.advance) begin
      mplier  <= {mplier[W-2:0], 1'b0};
      mul_cnt <= mul_cnt - CNT_W'(1);
    end
    if (cmd.wb) begin
      case (op)
        OP_MULR: r_reg <= acc;
        default: b_reg <= acc;
      endcase
    end
    if (cmd.exp_shift) begin
      e_reg   <= {1'b0, e_reg[W-1:1]};
      exp_cnt <= exp_cnt - CNT_W'(1);
    end
  end

  // Output register: a finished result waits here for the consumer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (cmd.push) begin
      out_full <= 1'b1;
    end else if (out_ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_data <= DATA_W'(r_reg);
    end
  end

  assign out_valid = out_full;

  // Status back to the controller.
  always_comb begin
    sts.m_small  = (m_reg <= W'(1));
    sts.mul_bit  = mplier[W-1];
    sts.mul_last = (mul_cnt == '0);
    sts.exp_bit  = e_reg[0];
    sts.exp_last = (exp_cnt == '0);
    sts.op       = op;
    sts.out_free = !out_full || out_ready;
  end

  // A held result is below the modulus unless the modulus is zero or one.
  assign out_reduced = sts.m_small || (out_data < DATA_W'(m_reg));

`include "modular_exponentiation_64_top_macros.svh"

  // The accumulator and multiplicand stay reduced throughout a multiply.
  `MEXP_ASSERT_HOLD(a_acc_reduced, clk, rst, !(cmd.dbl || cmd.add) || (acc < m_reg))
  `MEXP_ASSERT_HOLD(a_mcand_reduced, clk, rst, !(cmd.dbl || cmd.add) || (mcand < m_reg))
  // A delivered result is below a modulus of two or more.
  `MEXP_ASSERT_NEXT(a_result_reduced, clk, rst, cmd.push, out_full && out_reduced)

endmodule

// ===== rtl/core/mexp_ctrl.sv =====
// Controller: sequences reduction, multiplies and squarings over the exponent bits.
module mexp_ctrl import mexp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CHECK = 8'b0000_0010,
    S_ITER  = 8'b0000_0100,
    S_SQR   = 8'b0000_1000,
    S_DBL   = 8'b0001_0000,
    S_ADD   = 8'b0010_0000,
    S_WB    = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.op     = OP_SQR;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        // A modulus of zero or one gives zero; otherwise reduce the base first.
        if (sts.m_small) begin
          cmd.clear_r = 1'b1;
          state_next  = S_DONE;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.op        = OP_REDUCE;
          state_next    = S_DBL;
        end
      end
      S_ITER: begin
        cmd.mul_start = 1'b1;
        cmd.op        = sts.exp_bit ? OP_MULR : OP_SQR;
        state_next    = S_DBL;
      end
      S_SQR: begin
        cmd.mul_start = 1'b1;
        cmd.op        = OP_SQR;
        state_next    = S_DBL;
      end
      S_DBL: begin
        cmd.dbl     = 1'b1;
        cmd.advance = !sts.mul_bit;
        if (sts.mul_bit) begin
          state_next = S_ADD;
        end else if (sts.mul_last) begin
          state_next = S_WB;
        end
      end
      S_ADD: begin
        cmd.add     = 1'b1;
        cmd.advance = 1'b1;
        state_next  = sts.mul_last ? S_WB : S_DBL;
      end
      S_WB: begin
        cmd.wb = 1'b1;
        case (sts.op)
          OP_REDUCE: state_next = S_ITER;
          OP_MULR:   state_next = S_SQR;
          default: begin
            cmd.exp_shift = 1'b1;
            state_next    = sts.exp_last ? S_DONE : S_ITER;
          end
        endcase
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/modular_exponentiation_64_top.sv =====
// Top level: result = base ^ exponent mod modulus by right-to-left square-and-multiply.
// Each modular multiply runs setup, one doubling for each of the W = OPERAND_WIDTH multiplier
// bits, one addition per set bit, then writeback.
// A modulus of zero or one gives a zero result without any multiply.
// One request at a time, the next taken the cycle after a result; sync reset empties output.
module modular_exponentiation_64_top import mexp_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = 64
) (
  input logic       clk,
  input logic       rst,
  mexp_in_if.sink   operands,
  mexp_out_if.source result
);

  cmd_t cmd;
  sts_t sts;

  mexp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (operands.valid),
    .in_ready (operands.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mexp_dp #(
    .W (OPERAND_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .base_value     (operands.base_value),
    .exponent_value (operands.exponent_value),
    .modulus_value  (operands.modulus_value),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .out_data       (result.power_result)
  );

endmodule

// ===== tb/tb_modular_exponentiation_64_top.sv =====
// Self-checking testbench for the 64-bit modular exponentiation core.
module tb_modular_exponentiation_64_top import mexp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned OPERAND_W = 64;
  localparam int unsigned CYCLE_LIMIT = 8_000_000;
  localparam int unsigned DRAIN_CYCLES = 17_000;
  localparam int unsigned RANDOM_PER_PHASE = 20;
  localparam int unsigned NUM_DIRECTED = 22;

  localparam logic [DATA_W-1:0] ONES = '1;
  localparam logic [DATA_W-1:0] TOP_BIT = 64'h8000_0000_0000_0000;
  localparam logic [DATA_W-1:0] PRIME64 = 64'hFFFF_FFFF_FFFF_FFC5;

  // One directed request; the answer is used only when it is marked as known.
  typedef struct packed {
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] exponent;
    logic [DATA_W-1:0] modulus;
    logic              known;
    logic [DATA_W-1:0] answer;
  } power_case_t;

  power_case_t directed_cases [NUM_DIRECTED] = '{
    '{64'd0, 64'd0, 64'd0, 1'b1, 64'd0},
    '{ONES, ONES, 64'd0, 1'b1, 64'd0},
    '{ONES, ONES, 64'd1, 1'b1, 64'd0},
    '{64'd5, 64'd0, 64'd7, 1'b1, 64'd1},
    '{ONES, 64'd0, ONES, 1'b1, 64'd1},
    '{64'd0, 64'd5, 64'd13, 1'b1, 64'd0},
    '{64'd0, ONES, ONES, 1'b1, 64'd0},
    '{64'd13, 64'd3, 64'd13, 1'b1, 64'd0},
    '{64'd2, 64'd10, 64'd1000, 1'b1, 64'd24},
    '{64'd3, 64'd1, 64'd7, 1'b1, 64'd3},
    '{ONES, 64'd1, ONES, 1'b1, 64'd0},
    '{ONES, 64'd2, ONES - 64'd1, 1'b1, 64'd1},
    '{ONES - 64'd1, 64'd2, ONES, 1'b1, 64'd1},
    '{ONES - 64'd1, ONES, ONES, 1'b1, ONES - 64'd1},
    '{64'd1, ONES, 64'd2, 1'b1, 64'd1},
    '{ONES, ONES, 64'd2, 1'b1, 64'd1},
    '{64'd2, PRIME64 - 64'd1, PRIME64, 1'b1, 64'd1},
    '{64'd2, 64'd64, ONES, 1'b0, 64'd0},
    '{TOP_BIT, ONES, PRIME64, 1'b0, 64'd0},
    '{64'd3, ONES, TOP_BIT, 1'b0, 64'd0},
    '{64'hDEAD_BEEF_CAFE_F00D, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'd0},
    '{64'd7, 64'hAAAA_AAAA_AAAA_AAAA, TOP_BIT, 1'b0, 64'd0}
  };

  logic clk;
  logic rst;

  mexp_in_if  operands ();
  mexp_out_if result ();

  modular_exponentiation_64_top #(
    .OPERAND_WIDTH(OPERAND_W)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .operands (operands),
    .result   (result)
  );

  logic [DATA_W-1:0] pending_powers [$];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned powers_checked;
  int unsigned mismatches;
  int unsigned requests_sent;
  int unsigned small_modulus_requests;
  int unsigned cycles;

  // Base to the exponent modulo the modulus, with exact double-width products.
  function automatic logic [DATA_W-1:0] mod_pow(logic [DATA_W-1:0] base,
                                                logic [DATA_W-1:0] exponent,
                                                logic [DATA_W-1:0] modulus);
    logic [2*DATA_W-1:0] acc;
    logic [2*DATA_W-1:0] square;
    logic [2*DATA_W-1:0] wide_mod;
    int i;
    if (modulus == '0) begin
      return '0;
    end
    wide_mod = {{DATA_W{1'b0}}, modulus};
    acc = (modulus == 64'd1) ? '0 : {{(2*DATA_W-1){1'b0}}, 1'b1};
    square = {{DATA_W{1'b0}}, base} % wide_mod;
    for (i = 0; i < OPERAND_W; i++) begin
      if (exponent[i]) begin
        acc = (acc * square) % wide_mod;
      end
      square = (square * square) % wide_mod;
    end
    return acc[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // Pick a random request, weighted toward large moduli and boundary values.
  task automatic pick_operands(output logic [DATA_W-1:0] base,
                               output logic [DATA_W-1:0] exponent,
                               output logic [DATA_W-1:0] modulus);
    int unsigned sel;
    logic [DATA_W-1:0] shift_one;
    sel = $urandom_range(0, 99);
    shift_one = 64'd1 << $urandom_range(0, 63);
    if (sel < 40) begin
      modulus = rand_word() | TOP_BIT;
    end else if (sel < 65) begin
      modulus = rand_word();
    end else if (sel < 75) begin
      modulus = rand_word() & 64'hFFFF;
    end else if (sel < 80) begin
      modulus = DATA_W'($urandom_range(0, 1));
    end else if (sel < 90) begin
      modulus = $urandom_range(0, 1) ? shift_one : shift_one - 64'd1;
    end else begin
      modulus = ONES - DATA_W'($urandom_range(0, 64));
    end

    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      base = rand_word();
    end else if (sel < 68) begin
      base = '0;
    end else if (sel < 74) begin
      base = 64'd1;
    end else if (sel < 82) begin
      base = modulus - 64'd1;
    end else if (sel < 88) begin
      base = modulus;
    end else if (sel < 94) begin
      base = ONES;
    end else begin
      base = rand_word() & 64'hFFFF;
    end

    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      exponent = rand_word();
    end else if (sel < 68) begin
      exponent = '0;
    end else if (sel < 74) begin
      exponent = 64'd1;
    end else if (sel < 80) begin
      exponent = 64'd2;
    end else if (sel < 88) begin
      exponent = ONES;
    end else begin
      exponent = rand_word() & 64'hFF;
    end
  endtask

  // Queue the expected power, then hold the request until it is taken.
  task automatic send_request(logic [DATA_W-1:0] base, logic [DATA_W-1:0] exponent,
                              logic [DATA_W-1:0] modulus, logic [DATA_W-1:0] power);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      operands.valid <= 1'b0;
      @(posedge clk);
    end
    pending_powers.push_back(power);
    if (modulus < 2) begin
      small_modulus_requests++;
    end
    operands.valid          <= 1'b1;
    operands.base_value     <= base;
    operands.exponent_value <= exponent;
    operands.modulus_value  <= modulus;
    do @(posedge clk); while (!operands.ready);
    requests_sent++;
  endtask

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Cycle counter that stops a hung run.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Result side: random backpressure and comparison against the oldest expectation.
  initial begin
    logic [DATA_W-1:0] want;
    result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result.valid && result.ready) begin
        if (pending_powers.size() == 0) begin
          $error("power_result: no request outstanding, actual %h", result.power_result);
          mismatches++;
        end else begin
          want = pending_powers.pop_front();
          powers_checked++;
          if (result.power_result !== want) begin
            $error("power_result: expected %h, actual %h", want, result.power_result);
            mismatches++;
          end
        end
      end
      result.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Request side: reset, directed table, then four flow-control phases of random requests.
  initial begin
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] exponent;
    logic [DATA_W-1:0] modulus;
    logic [DATA_W-1:0] power;
    int unsigned phase;
    int unsigned n;

    send_idle_pct          = 0;
    recv_stall_pct         = 0;
    powers_checked         = 0;
    mismatches             = 0;
    requests_sent          = 0;
    small_modulus_requests = 0;

    rst                     <= 1'b1;
    operands.valid          <= 1'b0;
    operands.base_value     <= '0;
    operands.exponent_value <= '0;
    operands.modulus_value  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table; rows without a typed answer use the predictor.
    for (n = 0; n < NUM_DIRECTED; n++) begin
      power = directed_cases[n].known ? directed_cases[n].answer :
              mod_pow(directed_cases[n].base, directed_cases[n].exponent,
                      directed_cases[n].modulus);
      send_request(directed_cases[n].base, directed_cases[n].exponent,
                   directed_cases[n].modulus, power);
    end

    // Phases: no idling, sender idle, receiver stalling, both idling lightly.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 81;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 81;
        end
        default: begin
          send_idle_pct = 17;
          recv_stall_pct = 17;
        end
      endcase
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        pick_operands(base, exponent, modulus);
        send_request(base, exponent, modulus, mod_pow(base, exponent, modulus));
      end
    end
    operands.valid <= 1'b0;

    // Drain, then watch long enough for any stray result to show up.
    while (pending_powers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d powers from %0d requests (%0d directed, %0d with modulus 0 or 1).",
             powers_checked, requests_sent, NUM_DIRECTED, small_modulus_requests);
    $display("Random requests ran under four flow-control phases; %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/mexp_pkg.sv
rtl/core/mexp_if.sv
rtl/core/mexp_dp.sv
rtl/core/mexp_ctrl.sv
rtl/core/modular_exponentiation_64_top.sv
tb/tb_modular_exponentiation_64_top.sv
